// ===== rtl/coc_pkg.sv =====
package coc_pkg;

    // Cursor plane geometry: 16 rows of 16 pixels, bit 15 leftmost.
    localparam int PLANE_ROWS = 16;
    localparam int PLANE_COLS = 16;
    localparam int ROW_BITS   = 4;

    // Configuration register indexes on the write port.
    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_CURSOR_X      = 3'd2,
        REG_CURSOR_Y      = 3'd3,
        REG_HOT_X         = 3'd4,
        REG_HOT_Y         = 3'd5,
        REG_PIXEL_BYTES   = 3'd6,
        REG_CURSOR_ENABLE = 3'd7
    } cfg_reg_t;

    // Default arrow image and mask loaded at reset.
    localparam logic [PLANE_COLS-1:0] ARROW_SHAPE [PLANE_ROWS] = '{
        16'h0000, 16'h7FFE, 16'h7FFC, 16'h7FF8, 16'h7FF0, 16'h7FE0, 16'h7FC0, 16'h7FE0,
        16'h7FF0, 16'h7FF8, 16'h7CFC, 16'h787E, 16'h703C, 16'h6018, 16'h4000, 16'h0000
    };
    localparam logic [PLANE_COLS-1:0] ARROW_OUTLINE [PLANE_ROWS] = '{
        16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFC, 16'hFFF8, 16'hFFF0, 16'hFFE0, 16'hFFF0,
        16'hFFF8, 16'hFFFC, 16'hFFFE, 16'hFCFF, 16'hF87E, 16'hF03C, 16'hE018, 16'hC000
    };

    // Row write into both planes.
    typedef struct packed {
        logic                  en;
        logic [ROW_BITS-1:0]   row;
        logic [PLANE_COLS-1:0] shape;
        logic [PLANE_COLS-1:0] outline;
    } plane_wr_t;

    // Plane lookup result for one cursor spot.
    typedef struct packed {
        logic shape;
        logic outline;
    } plane_bits_t;

endpackage

// ===== rtl/coc_planes.sv =====
module coc_planes (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  coc_pkg::plane_wr_t                    wr,
    input  logic [coc_pkg::ROW_BITS-1:0]          rd_row,
    input  logic [coc_pkg::ROW_BITS-1:0]          rd_col,
    output coc_pkg::plane_bits_t                  bits
);

    logic [coc_pkg::PLANE_COLS-1:0] shape_reg   [coc_pkg::PLANE_ROWS];
    logic [coc_pkg::PLANE_COLS-1:0] outline_reg [coc_pkg::PLANE_ROWS];
    logic [coc_pkg::ROW_BITS-1:0]   bit_sel;

    // Reload the arrow on reset, take one row per load transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < coc_pkg::PLANE_ROWS; i++) begin
                shape_reg[i]   <= coc_pkg::ARROW_SHAPE[i];
                outline_reg[i] <= coc_pkg::ARROW_OUTLINE[i];
            end
        end else if (wr.en) begin
            shape_reg[wr.row]   <= wr.shape;
            outline_reg[wr.row] <= wr.outline;
        end
    end

    // Column 0 is the most significant bit of a row.
    assign bit_sel      = ~rd_col;
    assign bits.shape   = shape_reg[rd_row][bit_sel];
    assign bits.outline = outline_reg[rd_row][bit_sel];

endmodule

// ===== rtl/cursor_overlay_compositor.sv =====
// Cursor overlay compositor: 16x16 two-plane hardware cursor over a pixel stream.
// A pixel transfer accepted on s_axis passes the input register, the box compare register
// and the output register (a three-stage pipeline) before it shows on m_axis.
// Throughput: one item per cycle unless m_axis stalls; stalls back up stage by stage.
// Reset (aresetn low, synchronous): clears all valid bits, restores register defaults
// and reloads the default arrow into both cursor planes.
module cursor_overlay_compositor #(
    parameter int CURSOR_SIZE = 16,
    parameter int PIXEL_WIDTH = 32,
    parameter int COORD_BITS  = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // Configuration write port
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_addr,
    input  logic [12:0]            cfg_wdata,

    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata, low bit up: row_index, shape_bits, outline_bits, pix_x, pix_y, pix_value, zero fill
    input  logic [((coc_pkg::ROW_BITS + 2 * coc_pkg::PLANE_COLS + 2 * COORD_BITS
                    + PIXEL_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: req_type (0 load cursor row, 1 composite pixel)
    input  logic                   s_axis_tuser,

    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata, low bit up: pix_out, zero fill
    output logic [((PIXEL_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // tuser: cursor_hit
    output logic                   m_axis_tuser
);

    localparam int RB = coc_pkg::ROW_BITS;
    localparam int PC = coc_pkg::PLANE_COLS;
    localparam int M_TDATA_W = ((PIXEL_WIDTH + 7) / 8) * 8;

    // Field offsets inside s_axis_tdata.
    localparam int OFS_SHAPE   = RB;
    localparam int OFS_OUTLINE = OFS_SHAPE + PC;
    localparam int OFS_X       = OFS_OUTLINE + PC;
    localparam int OFS_Y       = OFS_X + COORD_BITS;
    localparam int OFS_PIX     = OFS_Y + COORD_BITS;

    // Signed width that holds a coordinate minus (pointer + hotspot).
    localparam int DW = ((COORD_BITS > 13) ? COORD_BITS : 13) + 3;
    // Spots beyond the 16x16 planes are transparent, so clip the box to them.
    localparam int BOX_LIM = (CURSOR_SIZE < PC) ? CURSOR_SIZE : PC;

    localparam logic [12:0] SCREEN_MAX  = 13'd4096;
    localparam logic [12:0] WIDTH_MIN   = 13'd4;
    localparam logic [12:0] HEIGHT_MIN  = 13'd1;

    // All-ones cursor color over the active bytes; 0 acts as 1, above 4 as 4.
    function automatic logic [31:0] fill_color(logic [2:0] pb);
        logic [31:0] c;
        unique case (pb)
            3'd0, 3'd1: c = 32'h0000_00FF;
            3'd2:       c = 32'h0000_FFFF;
            3'd3:       c = 32'h00FF_FFFF;
            default:    c = 32'hFFFF_FFFF;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [12:0]       screen_width_reg, screen_height_reg;
    logic [12:0]       cursor_x_reg, cursor_y_reg;
    logic signed [5:0] hot_x_reg, hot_y_reg;
    logic [2:0]        pixel_bytes_reg;
    logic              cursor_enable_reg;

    logic [12:0] width_wr, width_next, height_next, cursor_x_next, cursor_y_next;

    always_comb begin
        // Width: round down to a multiple of four, then clamp to 4..4096.
        width_wr = {cfg_wdata[12:2], 2'b00};
        priority if (width_wr < WIDTH_MIN) begin
            width_next = WIDTH_MIN;
        end else if (width_wr > SCREEN_MAX) begin
            width_next = SCREEN_MAX;
        end else begin
            width_next = width_wr;
        end

        priority if (cfg_wdata < HEIGHT_MIN) begin
            height_next = HEIGHT_MIN;
        end else if (cfg_wdata > SCREEN_MAX) begin
            height_next = SCREEN_MAX;
        end else begin
            height_next = cfg_wdata;
        end

        // Pointer saturates to the screen size in force at the time of the write.
        cursor_x_next = (cfg_wdata > screen_width_reg)  ? screen_width_reg  : cfg_wdata;
        cursor_y_next = (cfg_wdata > screen_height_reg) ? screen_height_reg : cfg_wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= 13'd640;
            screen_height_reg <= 13'd480;
            cursor_x_reg      <= '0;
            cursor_y_reg      <= '0;
            hot_x_reg         <= '0;
            hot_y_reg         <= '0;
            pixel_bytes_reg   <= 3'd4;
            cursor_enable_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (coc_pkg::cfg_reg_t'(cfg_addr))
                coc_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= width_next;
                coc_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= height_next;
                coc_pkg::REG_CURSOR_X:      cursor_x_reg      <= cursor_x_next;
                coc_pkg::REG_CURSOR_Y:      cursor_y_reg      <= cursor_y_next;
                coc_pkg::REG_HOT_X:         hot_x_reg         <= cfg_wdata[5:0];
                coc_pkg::REG_HOT_Y:         hot_y_reg         <= cfg_wdata[5:0];
                coc_pkg::REG_PIXEL_BYTES:   pixel_bytes_reg   <= cfg_wdata[2:0];
                coc_pkg::REG_CURSOR_ENABLE: cursor_enable_reg <= cfg_wdata[0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage advances when the stage after it
    // is empty or moving, so a stall at m_axis backs up one stage at a time
    // and bubbles are squeezed out.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic s1_ready, s2_ready, s3_ready;

    assign s3_ready      = !m_valid_reg || m_axis_tready;
    assign s2_ready      = !s2_valid_reg || s3_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic                   s1_is_pix_reg;
    logic [RB-1:0]          s1_row_reg;
    logic [PC-1:0]          s1_shape_reg, s1_outline_reg;
    logic [COORD_BITS-1:0]  s1_x_reg, s1_y_reg;
    logic [PIXEL_WIDTH-1:0] s1_pix_reg;

    always_ff @(posedge aclk) begin
        if (s1_ready && s_axis_tvalid) begin
            s1_is_pix_reg  <= s_axis_tuser;
            s1_row_reg     <= s_axis_tdata[RB-1:0];
            s1_shape_reg   <= s_axis_tdata[OFS_SHAPE +: PC];
            s1_outline_reg <= s_axis_tdata[OFS_OUTLINE +: PC];
            s1_x_reg       <= s_axis_tdata[OFS_X +: COORD_BITS];
            s1_y_reg       <= s_axis_tdata[OFS_Y +: COORD_BITS];
            s1_pix_reg     <= s_axis_tdata[OFS_PIX +: PIXEL_WIDTH];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cursor box position and screen clip
    // ------------------------------------------------------------------
    logic signed [DW-1:0] col_s, row_s;
    logic                 col_in, row_in, on_screen, cand_next;
    logic [RB-1:0]        s2_row_next;

    always_comb begin
        col_s = $signed(DW'(s1_x_reg)) - $signed(DW'(cursor_x_reg)) - DW'(hot_x_reg);
        row_s = $signed(DW'(s1_y_reg)) - $signed(DW'(cursor_y_reg)) - DW'(hot_y_reg);

        col_in = !col_s[DW-1] && (col_s[DW-2:0] < (DW-1)'(BOX_LIM));
        row_in = !row_s[DW-1] && (row_s[DW-2:0] < (DW-1)'(BOX_LIM));

        on_screen = (DW'(s1_x_reg) < DW'(screen_width_reg)) &&
                    (DW'(s1_y_reg) < DW'(screen_height_reg));

        cand_next = cursor_enable_reg && on_screen && col_in && row_in;

        // A load carries its target row; a pixel carries its box row.
        s2_row_next = s1_is_pix_reg ? row_s[RB-1:0] : s1_row_reg;
    end

    logic                   s2_is_pix_reg, s2_cand_reg;
    logic [RB-1:0]          s2_row_reg, s2_col_reg;
    logic [PC-1:0]          s2_shape_reg, s2_outline_reg;
    logic [PIXEL_WIDTH-1:0] s2_pix_reg;

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_is_pix_reg  <= s1_is_pix_reg;
            s2_cand_reg    <= cand_next;
            s2_row_reg     <= s2_row_next;
            s2_col_reg     <= col_s[RB-1:0];
            s2_shape_reg   <= s1_shape_reg;
            s2_outline_reg <= s1_outline_reg;
            s2_pix_reg     <= s1_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: plane lookup and color select. Loads write the planes as they
    // leave stage 2, and pixels read them at the same point, so every pixel
    // sees exactly the loads that came before it.
    // ------------------------------------------------------------------
    coc_pkg::plane_wr_t   plane_wr;
    coc_pkg::plane_bits_t plane_bits;

    assign plane_wr.en      = s2_valid_reg && !s2_is_pix_reg && s3_ready;
    assign plane_wr.row     = s2_row_reg;
    assign plane_wr.shape   = s2_shape_reg;
    assign plane_wr.outline = s2_outline_reg;

    coc_planes u_planes (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (plane_wr),
        .rd_row  (s2_row_reg),
        .rd_col  (s2_col_reg),
        .bits    (plane_bits)
    );

    logic                   hit_next;
    logic [PIXEL_WIDTH-1:0] pix_next;
    logic [PIXEL_WIDTH-1:0] m_pix_reg;
    logic                   m_hit_reg;

    always_comb begin
        hit_next = s2_cand_reg && (plane_bits.shape || plane_bits.outline);
        // Shape bit draws black, outline alone draws all-ones over the active bytes.
        priority if (!hit_next) begin
            pix_next = s2_pix_reg;
        end else if (plane_bits.shape) begin
            pix_next = '0;
        end else begin
            pix_next = PIXEL_WIDTH'(fill_color(pixel_bytes_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_ready && s2_valid_reg && s2_is_pix_reg) begin
            m_pix_reg <= pix_next;
            m_hit_reg <= hit_next;
        end
    end

    // Valid bits; loads drop out after stage 2 and never reach m_axis.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                m_valid_reg <= s2_valid_reg && s2_is_pix_reg;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(m_pix_reg);
    assign m_axis_tuser  = m_hit_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A load leaving stage 2 leaves no result behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && !s2_is_pix_reg && s3_ready) |=> !m_valid_reg)
        else $error("load transfer produced a result");

    // A pixel leaving stage 2 always lands in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && s2_is_pix_reg && s3_ready) |=> m_valid_reg)
        else $error("pixel transfer lost between stage 2 and output");

    // Input backpressure only when every stage is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (s1_valid_reg && s2_valid_reg && m_valid_reg))
        else $error("input stalled with a free pipeline stage");

endmodule

// ===== tb/sv/cursor_overlay_compositor_test.sv =====
`timescale 1ns / 100ps

module cursor_overlay_compositor_test;

    localparam int CURSOR_SIZE  = 16;
    localparam int PIX_W        = 32;
    localparam int COORD_W      = 12;
    localparam int S_TDATA_W    =
        ((4 + 2 * coc_pkg::PLANE_COLS + 2 * COORD_W + PIX_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((PIX_W + 7) / 8) * 8;
    // Margin for the pipeline to drain before touching registers.
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_SETUPS    = 12;
    localparam int ITEMS_PER_SETUP  = 150;

    // Kind of an input transfer, carried on s_axis_tuser.
    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_PIXEL = 1'b1
    } req_kind_t;

    // One composited pixel as it should leave the block.
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             hit;
    } overlay_t;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [2:0]           cfg_addr      = '0;
    logic [12:0]          cfg_wdata     = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // tdata, low bit up: row_index, shape_bits, outline_bits, pix_x, pix_y, pix_value, zero fill
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // tuser: req_type
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tdata, low bit up: pix_out
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // tuser: cursor_hit
    logic                 m_axis_tuser;

    // Predictor state: cursor planes and the register file as the block should hold them.
    logic [coc_pkg::PLANE_COLS-1:0] shape_rows   [coc_pkg::PLANE_ROWS];
    logic [coc_pkg::PLANE_COLS-1:0] outline_rows [coc_pkg::PLANE_ROWS];
    logic [12:0] scr_w     = 13'd640;
    logic [12:0] scr_h     = 13'd480;
    logic [12:0] cur_x     = '0;
    logic [12:0] cur_y     = '0;
    int          hot_x_off = 0;
    int          hot_y_off = 0;
    logic [2:0]  pix_bytes = 3'd4;
    logic        cursor_on = 1'b0;

    // Pixels in flight, oldest first.
    overlay_t expected_pixels [$];

    int mismatches     = 0;
    int items_sent     = 0;
    int pixels_checked = 0;
    int hits_seen      = 0;
    int setups_done    = 0;
    int source_quiet   = 0;
    int sink_quiet     = 0;
    int sink_hold      = 0;

    cursor_overlay_compositor u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("cursor_overlay_compositor test failed");
        $finish;
    end

    // Idle length for either side: mostly zero, some short, a few long, and now and
    // then a quiet stretch with no idling at all.
    function automatic int pick_gap(inout int quiet_left);
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            quiet_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Expected output for one pixel transfer under the current registers and planes.
    function automatic overlay_t overlay_pixel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                               logic [PIX_W-1:0] value);
        overlay_t r;
        int       col;
        int       row;
        int       nb;
        logic     s;
        logic     o;
        r.pix = value;
        r.hit = 1'b0;
        // Box corner is pointer plus hotspot; hotspot may push it off the screen.
        col = int'(px) - (int'(cur_x) + hot_x_off);
        row = int'(py) - (int'(cur_y) + hot_y_off);
        if (cursor_on && px < scr_w && py < scr_h &&
            col >= 0 && col < CURSOR_SIZE && row >= 0 && row < CURSOR_SIZE &&
            col < coc_pkg::PLANE_COLS && row < coc_pkg::PLANE_ROWS) begin
            // Bit 15 of a row is the leftmost cursor pixel.
            s = shape_rows[row][coc_pkg::PLANE_COLS-1-col];
            o = outline_rows[row][coc_pkg::PLANE_COLS-1-col];
            if (s || o) begin
                r.hit = 1'b1;
                if (s) begin
                    r.pix = '0;
                end else begin
                    // Out-of-range byte counts fold to 1 or 4.
                    nb = (pix_bytes == 3'd0) ? 1 : (pix_bytes > 3'd4) ? 4 : int'(pix_bytes);
                    r.pix = PIX_W'((64'd1 << (8 * nb)) - 64'd1);
                end
            end
        end
        return r;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_item(logic [3:0] row, logic [15:0] shape,
                                                       logic [15:0] outline,
                                                       logic [COORD_W-1:0] px,
                                                       logic [COORD_W-1:0] py,
                                                       logic [PIX_W-1:0] value);
        return S_TDATA_W'({value, py, px, outline, shape, row});
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 200)
            $display("%0t ns: mismatch on %s: got 0x%08h, want 0x%08h", $time, what, got, want);
        mismatches++;
    endtask

    // Write one register at the next edge, then mirror it in the predictor.
    task automatic write_reg(input coc_pkg::cfg_reg_t idx, input logic [12:0] value);
        logic [12:0] v;
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        v = value;
        case (idx)
            coc_pkg::REG_SCREEN_WIDTH: begin
                // Round down to a multiple of four, then clamp.
                v = v & ~13'd3;
                if (v < 13'd4) v = 13'd4;
                if (v > 13'd4096) v = 13'd4096;
                scr_w = v;
            end
            coc_pkg::REG_SCREEN_HEIGHT: begin
                if (v < 13'd1) v = 13'd1;
                if (v > 13'd4096) v = 13'd4096;
                scr_h = v;
            end
            // Pointer saturates against the screen size in force now; no later re-clamp.
            coc_pkg::REG_CURSOR_X:      cur_x = (v > scr_w) ? scr_w : v;
            coc_pkg::REG_CURSOR_Y:      cur_y = (v > scr_h) ? scr_h : v;
            coc_pkg::REG_HOT_X:         hot_x_off = int'($signed(value[5:0]));
            coc_pkg::REG_HOT_Y:         hot_y_off = int'($signed(value[5:0]));
            coc_pkg::REG_PIXEL_BYTES:   pix_bytes = value[2:0];
            coc_pkg::REG_CURSOR_ENABLE: cursor_on = value[0];
            default: ;
        endcase
    endtask

    task automatic setup_all(input logic [12:0] w, input logic [12:0] h,
                             input logic [12:0] cx, input logic [12:0] cy,
                             input logic [12:0] hx, input logic [12:0] hy,
                             input logic [12:0] nb, input logic [12:0] en);
        write_reg(coc_pkg::REG_SCREEN_WIDTH, w);
        write_reg(coc_pkg::REG_SCREEN_HEIGHT, h);
        write_reg(coc_pkg::REG_CURSOR_X, cx);
        write_reg(coc_pkg::REG_CURSOR_Y, cy);
        write_reg(coc_pkg::REG_HOT_X, hx);
        write_reg(coc_pkg::REG_HOT_Y, hy);
        write_reg(coc_pkg::REG_PIXEL_BYTES, nb);
        write_reg(coc_pkg::REG_CURSOR_ENABLE, en);
        setups_done++;
    endtask

    // Drop valid, let every expected pixel come back, then let the pipeline drain.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Offer one transfer after a random gap, hold it until accepted, then predict.
    task automatic send_item(input req_kind_t kind, input logic [3:0] row,
                             input logic [15:0] shape, input logic [15:0] outline,
                             input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                             input logic [PIX_W-1:0] value);
        int gap;
        gap = pick_gap(source_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= pack_item(row, shape, outline, px, py, value);
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
        if (kind == REQ_LOAD) begin
            shape_rows[row]   = shape;
            outline_rows[row] = outline;
        end else begin
            expected_pixels.push_back(overlay_pixel(px, py, value));
        end
    endtask

    task automatic send_pixel(input int x, input int y, input logic [PIX_W-1:0] value);
        send_item(REQ_PIXEL, 4'($urandom), 16'($urandom), 16'($urandom),
                  COORD_W'(x), COORD_W'(y), value);
    endtask

    task automatic send_load(input int row, input logic [15:0] shape, input logic [15:0] outline);
        send_item(REQ_LOAD, 4'(row), shape, outline,
                  COORD_W'($urandom), COORD_W'($urandom), PIX_W'($urandom));
    endtask

    function automatic logic [15:0] plane_pattern();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 16'h0000;
        if (r < 30) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Accept side: random back-pressure, then compare each transfer with the oldest pixel.
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            sink_hold = pick_gap(sink_quiet);
            m_axis_tready <= (sink_hold == 0);
            if (sink_hold > 0) sink_hold--;
        end
    end

    always @(posedge aclk) begin
        overlay_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected result transfer", m_axis_tdata, '0);
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (m_axis_tdata !== want.pix)
                    report_mismatch("pix_out", m_axis_tdata, want.pix);
                if (m_axis_tuser !== want.hit)
                    report_mismatch("cursor_hit", 32'(m_axis_tuser), 32'(want.hit));
                if (want.hit) hits_seen++;
            end
        end
    end

    // Default arrow after reset: invisible until enabled, then outline and shape both draw.
    task automatic test_reset_arrow();
        send_pixel(0, 0, 32'h1234_5678);
        wait_idle();
        write_reg(coc_pkg::REG_CURSOR_ENABLE, 13'd1);
        send_pixel(0, 0, 32'h1234_5678);
        send_pixel(1, 1, 32'hFFFF_FFFF);
        send_pixel(15, 15, 32'h0000_0000);
        send_pixel(16, 0, 32'h5555_AAAA);
        send_pixel(0, 16, 32'hAAAA_5555);
    endtask

    // Plane loads at both extremes, pixel value extremes and the far corner of the grid.
    task automatic test_field_extremes();
        send_load(0, 16'h0000, 16'h0000);
        send_load(15, 16'hFFFF, 16'hFFFF);
        send_load(7, 16'h0000, 16'hFFFF);
        send_pixel(0, 0, 32'hFFFF_FFFF);
        send_pixel(15, 15, 32'h0000_0000);
        send_pixel(3, 7, 32'h0000_0000);
        send_pixel(4095, 4095, 32'hFFFF_FFFF);
        send_pixel(639, 479, 32'hAAAA_AAAA);
    endtask

    // Register clamps, pointer saturation, hotspot sign and pixel size folding.
    task automatic test_register_limits();
        wait_idle();
        // Everything above range: screen 4096 square, pointer saturates, hotspot -16/-32,
        // byte count of zero acts as one.
        setup_all(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FF0, 13'h0020, 13'd0, 13'd1);
        send_pixel(4095, 4095, 32'h0F0F_0F0F);
        send_pixel(4080, 4071, 32'h0000_0000);
        send_pixel(4081, 4064, 32'h1111_1111);
        wait_idle();
        // Shrink the screen below its minimum; the pointer keeps its old value.
        write_reg(coc_pkg::REG_SCREEN_WIDTH, 13'd2);
        write_reg(coc_pkg::REG_SCREEN_HEIGHT, 13'd0);
        send_pixel(4095, 4095, 32'h2222_2222);
        send_pixel(0, 0, 32'h3333_3333);
        wait_idle();
        // Cursor partly left of the screen, hotspot +31 vertically, byte count above four.
        setup_all(13'd642, 13'd480, 13'd0, 13'd0, 13'h0038, 13'h001F, 13'd7, 13'd1);
        send_pixel(0, 31, 32'h4444_4444);
        send_pixel(7, 38, 32'h5555_5555);
        send_pixel(1, 45, 32'h6666_6666);
    endtask

    task automatic random_setup();
        logic [12:0] w;
        logic [12:0] h;
        logic [12:0] cx;
        logic [12:0] cy;
        logic [5:0]  hx;
        logic [5:0]  hy;
        w  = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 300));
        h  = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 200));
        hx = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'(int'($urandom_range(0, 32)) - 16);
        hy = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'(int'($urandom_range(0, 32)) - 16);
        write_reg(coc_pkg::REG_SCREEN_WIDTH, w);
        write_reg(coc_pkg::REG_SCREEN_HEIGHT, h);
        // Pointer mostly on screen, sometimes hugging an edge, sometimes wildly out.
        case ($urandom_range(0, 3))
            0:       cx = 13'($urandom);
            1:       cx = 13'(int'(scr_w) - int'($urandom_range(0, 20)));
            default: cx = 13'($urandom_range(0, scr_w));
        endcase
        case ($urandom_range(0, 3))
            0:       cy = 13'($urandom);
            1:       cy = 13'(int'(scr_h) - int'($urandom_range(0, 20)));
            default: cy = 13'($urandom_range(0, scr_h));
        endcase
        write_reg(coc_pkg::REG_CURSOR_X, cx);
        write_reg(coc_pkg::REG_CURSOR_Y, cy);
        write_reg(coc_pkg::REG_HOT_X, {7'($urandom), hx});
        write_reg(coc_pkg::REG_HOT_Y, {7'($urandom), hy});
        write_reg(coc_pkg::REG_PIXEL_BYTES, {10'($urandom), 3'($urandom_range(0, 7))});
        write_reg(coc_pkg::REG_CURSOR_ENABLE,
                  {12'($urandom), 1'($urandom_range(0, 5) != 0)});
        // Resize after the pointer was placed: pointer must not be re-clamped.
        if ($urandom_range(0, 3) == 0)
            write_reg(coc_pkg::REG_SCREEN_WIDTH, 13'($urandom_range(0, 300)));
        setups_done++;
    endtask

    task automatic send_random_pixel();
        int bx;
        int by;
        int x;
        int y;
        int r;
        logic [PIX_W-1:0] value;
        bx = int'(cur_x) + hot_x_off;
        by = int'(cur_y) + hot_y_off;
        r  = $urandom_range(0, 99);
        if (r < 70) begin
            x = bx + int'($urandom_range(0, 18)) - 2;
            y = by + int'($urandom_range(0, 18)) - 2;
        end else if (r < 85) begin
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
        end else begin
            // Straddle the right and bottom screen borders.
            x = int'(scr_w) + int'($urandom_range(0, 3)) - 2;
            y = int'(scr_h) + int'($urandom_range(0, 3)) - 2;
        end
        r = $urandom_range(0, 19);
        value = (r == 0) ? '0 : (r == 1) ? '1 : PIX_W'($urandom);
        send_pixel(x, y, value);
    endtask

    // Random setups, each optionally starting with a full sprite upload, then a mix
    // of row loads and pixels aimed mostly at the cursor box.
    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_SETUPS; phase++) begin
            wait_idle();
            random_setup();
            if ($urandom_range(0, 1) == 1) begin
                for (int row = 0; row < coc_pkg::PLANE_ROWS; row++)
                    send_load(row, plane_pattern(), plane_pattern());
            end
            for (int n = 0; n < ITEMS_PER_SETUP; n++) begin
                if ($urandom_range(0, 9) < 2)
                    send_load($urandom_range(0, coc_pkg::PLANE_ROWS - 1),
                              plane_pattern(), plane_pattern());
                else
                    send_random_pixel();
            end
        end
    endtask

    initial begin
        shape_rows   = coc_pkg::ARROW_SHAPE;
        outline_rows = coc_pkg::ARROW_OUTLINE;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_arrow();
        test_field_extremes();
        test_register_limits();
        test_random_traffic();
        wait_idle();

        $display("Sent %0d transfers in %0d setups; checked %0d pixels, %0d drawn by the cursor.",
                 items_sent, setups_done, pixels_checked, hits_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("cursor_overlay_compositor test passed");
        end else begin
            $display("cursor_overlay_compositor test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/coc_pkg.sv
rtl/coc_planes.sv
rtl/cursor_overlay_compositor.sv
tb/sv/cursor_overlay_compositor_test.sv
